[rtl/sbus_frame_decoder_assert.svh]
// assertion macros shared by the checker files of the sbus frame decoder
// depends on nothing; include by bare file name
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SBFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbus frame decoder assertion failed");

// next-cycle implication, disabled in reset
`define SBFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbus frame decoder assertion failed");

`endif

[rtl/sbfd_pkg.sv]
// constants and shared types of the sbus frame decoder
// used by the controller, the datapath and the top level
package sbfd_pkg;

   localparam int BYTE_W       = 8;
   localparam int CHAN_BITS    = 11;
   localparam int NUM_CHANNELS = 16;
   localparam int CHAN_IDX_W   = 4;
   localparam int PAYLOAD_BYTES = 22;
   localparam int PAYLOAD_BITS = PAYLOAD_BYTES * BYTE_W;
   localparam int POS_W        = 5;

   localparam logic [BYTE_W-1:0]     HEADER_BYTE = 8'h0F;
   localparam logic [BYTE_W-1:0]     FOOTER_BYTE = 8'h00;
   localparam logic [POS_W-1:0]      POS_FIRST   = 5'd1;
   localparam logic [POS_W-1:0]      POS_FLAGS   = 5'd23;
   localparam logic [CHAN_IDX_W-1:0] LAST_CHAN   = 4'd15;
   localparam int                    LOST_BIT    = 2;
   localparam int                    FS_BIT      = 3;

   // controller to datapath
   typedef struct packed {
      logic store_payload;
      logic store_flags;
      logic start_emit;
      logic advance;
   } sbfd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_header;
      logic is_footer;
      logic last_chan;
   } sbfd_status_type;

endpackage

[rtl/sbfd_datapath.sv]
// datapath of the sbus frame decoder: payload shift line, flags byte,
// channel counter and result fields; depends on sbfd_pkg
module sbfd_datapath
   import sbfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  sbfd_cmd_type          cmd,
   output sbfd_status_type       status,
   output logic [CHAN_IDX_W-1:0] rsp_channel_index,
   output logic [CHAN_BITS-1:0]  rsp_channel_value,
   output logic                  rsp_lost_flag,
   output logic                  rsp_failsafe,
   output logic                  rsp_last
);

   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [BYTE_W-1:0]       flags_ff, flags_in;
   logic [CHAN_IDX_W-1:0]   chan_ff, chan_in;

   always_comb begin
      payload_in = payload_ff;
      flags_in   = flags_ff;
      chan_in    = chan_ff;
      // bytes enter at the top so the first payload byte ends at bit 0
      if (cmd.store_payload) begin
         payload_in = {req_byte_value, payload_ff[PAYLOAD_BITS-1:BYTE_W]};
      end
      if (cmd.store_flags) begin
         flags_in = req_byte_value;
      end
      if (cmd.start_emit) begin
         chan_in = '0;
      end
      // drop the channel just delivered, next one moves to bit 0
      if (cmd.advance) begin
         payload_in = {CHAN_BITS'(0), payload_ff[PAYLOAD_BITS-1:CHAN_BITS]};
         chan_in    = chan_ff + CHAN_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      flags_ff   <= flags_in;
      if (reset) begin
         chan_ff <= '0;
      end else begin
         chan_ff <= chan_in;
      end
   end

   assign status.is_header = (req_byte_value == HEADER_BYTE);
   assign status.is_footer = (req_byte_value == FOOTER_BYTE);
   assign status.last_chan = (chan_ff == LAST_CHAN);

   assign rsp_channel_index = chan_ff;
   assign rsp_channel_value = payload_ff[CHAN_BITS-1:0];
   assign rsp_lost_flag     = flags_ff[LOST_BIT];
   assign rsp_failsafe      = flags_ff[FS_BIT];
   assign rsp_last          = status.last_chan;

endmodule

[rtl/sbfd_ctrl.sv]
// frame controller of the sbus frame decoder: header hunt, byte position,
// footer check and result sequencing; depends on sbfd_pkg
module sbfd_ctrl
   import sbfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  sbfd_status_type status,
   output sbfd_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_BODY,
      ST_FOOTER,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             req_take;
   logic             rsp_take;

   assign req_stall = (state_ff == ST_EMIT);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cmd      = '0;
      case (state_ff)
         ST_HUNT: begin
            if (req_take && status.is_header) begin
               state_in = ST_BODY;
               pos_in   = POS_FIRST;
            end
         end
         ST_BODY: begin
            if (req_take) begin
               if (pos_ff == POS_FLAGS) begin
                  cmd.store_flags = 1'b1;
                  state_in        = ST_FOOTER;
               end else begin
                  cmd.store_payload = 1'b1;
                  pos_in            = pos_ff + POS_W'(1);
               end
            end
         end
         ST_FOOTER: begin
            // footer byte is consumed either way, bad footer drops the frame
            if (req_take) begin
               if (status.is_footer) begin
                  cmd.start_emit = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               cmd.advance = 1'b1;
               if (status.last_chan) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

[rtl/sbus_frame_decoder.sv]
// Top level of the sbus frame decoder: controller plus datapath.
// Depends on sbfd_pkg, sbfd_ctrl and sbfd_datapath.
//
// Input channel (req_): one received byte per word, in serial order.
// Bytes are taken one per cycle while a frame is being collected. Before a
// header byte 0x0F the block ignores bytes; after it, 22 payload bytes and
// the flags byte are stored, and the next byte is checked as footer 0x00.
// A bad footer drops the frame with no output.
// Result channel (rsp_): on a good footer the block delivers 16 words, one
// per channel in channel order, rsp_last set on channel 15. The first word
// is valid the cycle after the footer is taken; then one word per cycle
// while rsp_stall is low. The 16-word burst ends when the channel counter
// reaches 15, and the payload line shifts by one channel per delivered
// word. While the burst is pending req_stall is high; a stalled result
// word holds its value until taken.
// Reset (synchronous, active high) returns the block to header hunting and
// drops any partial frame or pending burst.
module sbus_frame_decoder
   import sbfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_byte_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_IDX_W-1:0] rsp_channel_index,
   output logic [CHAN_BITS-1:0]  rsp_channel_value,
   output logic                  rsp_lost_flag,
   output logic                  rsp_failsafe,
   output logic                  rsp_last
);

   sbfd_cmd_type    cmd;
   sbfd_status_type status;

   sbfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sbfd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_byte_value    (req_byte_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_lost_flag     (rsp_lost_flag),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_last          (rsp_last)
   );

endmodule

[rtl/sbfd_checker.sv]
// port-level checker for the sbus frame decoder, bound to the top level
// depends on sbus_frame_decoder_assert.svh
`include "sbus_frame_decoder_assert.svh"

module sbfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_byte_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_channel_index,
   input logic [10:0] rsp_channel_value,
   input logic        rsp_lost_flag,
   input logic        rsp_failsafe,
   input logic        rsp_last
);

   logic rsp_held;
   logic rsp_step;
   logic rsp_end;
   logic in_seen;

   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_step = rsp_valid && !rsp_stall && !rsp_last;
   assign rsp_end  = rsp_valid && !rsp_stall && rsp_last;
   // keeps the input ports visible to the checker
   assign in_seen  = req_valid || (req_byte_value != 8'h00) || 1'b1;

   `SBFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_channel_index) && $stable(rsp_channel_value) && $stable(rsp_lost_flag) && $stable(rsp_failsafe))
   `SBFD_ASSERT_IMPLY(a_no_input_in_burst, clock, reset, rsp_valid && in_seen, req_stall)
   `SBFD_ASSERT_NEXT(a_chan_step, clock, reset, rsp_step, rsp_valid && (rsp_channel_index == $past(rsp_channel_index) + 4'd1))
   `SBFD_ASSERT_NEXT(a_burst_end, clock, reset, rsp_end, !rsp_valid)
   `SBFD_ASSERT_IMPLY(a_burst_start, clock, reset, $rose(rsp_valid), rsp_channel_index == 4'd0)

endmodule

bind sbus_frame_decoder sbfd_checker u_checker (.*);

[tb/sbus_frame_decoder_check.sv]
// checker for the sbus frame decoder: tracks frame bytes taken on req_,
// predicts the channel words and compares them with the words taken on rsp_
// depends on sbfd_pkg
module sbus_frame_decoder_check
   import sbfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CHAN_IDX_W-1:0] rsp_channel_index,
   input  logic [CHAN_BITS-1:0]  rsp_channel_value,
   input  logic                  rsp_lost_flag,
   input  logic                  rsp_failsafe,
   input  logic                  rsp_last,
   output int                    failures,
   output int                    words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAN_IDX_W-1:0] index;
      logic [CHAN_BITS-1:0]  value;
      logic                  lost;
      logic                  fs;
      logic                  last;
   } channel_word_type;

   localparam logic [POS_W-1:0] POS_FOOTER = POS_FLAGS + 1'b1;

   logic [POS_W-1:0]  frame_pos = '0;
   logic [BYTE_W-1:0] frame_bytes [PAYLOAD_BYTES + 1];
   channel_word_type  channel_q [$];
   channel_word_type  want;
   int                fail_total = 0;

   task automatic compare_field(input string name, input logic [15:0] exp,
                                input logic [15:0] act);
      if (act !== exp) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
         fail_total++;
      end
   endtask

   // payload is one lsb-first bit stream, 11 bits per channel
   task automatic decode_frame();
      logic [PAYLOAD_BITS-1:0] stream;
      logic [BYTE_W-1:0]       flags;
      channel_word_type        word;
      for (int i = 0; i < PAYLOAD_BYTES; i++)
         stream[i*BYTE_W +: BYTE_W] = frame_bytes[i];
      flags = frame_bytes[POS_FLAGS - POS_FIRST];
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         word.index = CHAN_IDX_W'(k);
         word.value = stream[k*CHAN_BITS +: CHAN_BITS];
         word.lost  = flags[LOST_BIT];
         word.fs    = flags[FS_BIT];
         word.last  = (word.index == LAST_CHAN);
         channel_q.push_back(word);
      end
   endtask

   task automatic take_byte(input logic [BYTE_W-1:0] b);
      if (frame_pos == '0 || frame_pos > POS_FOOTER) begin
         frame_pos = (b == HEADER_BYTE) ? POS_FIRST : '0;
      end else if (frame_pos < POS_FOOTER) begin
         frame_bytes[frame_pos - POS_FIRST] = b;
         frame_pos = frame_pos + 1'b1;
      end else begin
         // footer slot: consumed either way, back to hunting
         frame_pos = '0;
         if (b == FOOTER_BYTE)
            decode_frame();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_pos = '0;
         channel_q.delete();
      end else begin
         // check before predicting so a stray word cannot match this edge's frame
         if (rsp_valid && !rsp_stall) begin
            if (channel_q.size() == 0) begin
               $error("unexpected word: channel_index %0d channel_value %0d",
                      rsp_channel_index, rsp_channel_value);
               fail_total++;
            end else begin
               want = channel_q.pop_front();
               compare_field("channel_index", want.index, rsp_channel_index);
               compare_field("channel_value", want.value, rsp_channel_value);
               compare_field("lost_flag", want.lost, rsp_lost_flag);
               compare_field("failsafe", want.fs, rsp_failsafe);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall)
            take_byte(req_byte_value);
      end
      failures <= fail_total;
      words_pending <= channel_q.size();
   end

endmodule

[tb/sbus_frame_decoder_test.sv]
// top of the sbus frame decoder testbench: clock, reset, frame stimulus,
// receiver stalls and the verdict
// depends on sbfd_pkg, sbus_frame_decoder and sbus_frame_decoder_check
module sbus_frame_decoder_test
   import sbfd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_HEADER, FILL_RANDOM} fill_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_byte_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_IDX_W-1:0] rsp_channel_index;
   logic [CHAN_BITS-1:0]  rsp_channel_value;
   logic                  rsp_lost_flag;
   logic                  rsp_failsafe;
   logic                  rsp_last;
   int                    failures;
   int                    words_pending;
   int                    send_calm = 0;
   int                    bytes_sent = 0;

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   sbus_frame_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_lost_flag     (rsp_lost_flag),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_last          (rsp_last)
   );

   sbus_frame_decoder_check check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_lost_flag     (rsp_lost_flag),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_last          (rsp_last),
      .failures          (failures),
      .words_pending     (words_pending)
   );

   // idle cycles before a word; now and then a run of back-to-back words
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= value;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_frame(input fill_kind_type fill, input logic [BYTE_W-1:0] flags,
                             input logic [BYTE_W-1:0] footer);
      logic [BYTE_W-1:0] data;
      send_byte(HEADER_BYTE);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         case (fill)
            FILL_ZERO:   data = 8'h00;
            FILL_ONES:   data = 8'hFF;
            FILL_HEADER: data = HEADER_BYTE;
            default:     data = BYTE_W'($urandom);
         endcase
         send_byte(data);
      end
      send_byte(flags);
      send_byte(footer);
   endtask

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls, plus two long hold-offs so the block backs up
   initial begin
      int words_taken;
      int wait_cycles;
      int recv_calm;
      words_taken = 0;
      recv_calm = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (words_taken == 20 || words_taken == 100)
            wait_cycles = 300;
         else
            wait_cycles = draw_wait(recv_calm);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         words_taken++;
      end
   end

   initial begin
      fill_kind_type     fill;
      logic [BYTE_W-1:0] footer;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // junk while hunting, then all-ones, header-filled with a bad footer, all-zero
      send_byte(8'hFF);
      send_byte(FOOTER_BYTE);
      send_frame(FILL_ONES, 8'hFF, FOOTER_BYTE);
      send_frame(FILL_HEADER, 8'h0C, HEADER_BYTE);
      send_frame(FILL_ZERO, 8'h00, FOOTER_BYTE);

      while (bytes_sent < 250) begin
         case ($urandom_range(0, 9))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            2:       fill = FILL_HEADER;
            default: fill = FILL_RANDOM;
         endcase
         if ($urandom_range(0, 3) != 0)
            footer = FOOTER_BYTE;
         else if ($urandom_range(0, 1) == 0)
            footer = HEADER_BYTE;
         else
            footer = BYTE_W'($urandom_range(1, 255));
         send_frame(fill, BYTE_W'($urandom), footer);
         // stray bytes between frames
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/sbfd_pkg.sv
rtl/sbfd_datapath.sv
rtl/sbfd_ctrl.sv
rtl/sbus_frame_decoder.sv
rtl/sbfd_checker.sv
tb/sbus_frame_decoder_check.sv
tb/sbus_frame_decoder_test.sv
